### rtl/ppab_pkg.sv
// Shared constants and lookup functions for the parallel port to ATAPI bridge.
// Used by the bridge top level and by the register file RAM.
package ppab_pkg;

  localparam int BYTE_W    = 8;
  localparam int REG_COUNT = 32;

  // Unlock preamble byte at each match position (positions 0 to 6).
  function automatic logic [7:0] preamble_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h22;
      3'd1:    b = 8'hAA;
      3'd2:    b = 8'h55;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'hFF;
      3'd5:    b = 8'h87;
      3'd6:    b = 8'h78;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Register contents right after a device reset of the task file.
  function automatic logic [7:0] taskfile_default(input logic [7:0] addr);
    logic [7:0] b;
    unique case (addr)
      8'h1F:   b = 8'h50;
      8'h1C:   b = 8'h14;
      8'h1D:   b = 8'hEB;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/ppab_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on ppab_pkg for its default data width.
module ppab_ram #(
  parameter int WIDTH = ppab_pkg::BYTE_W,
  parameter int DEPTH = ppab_pkg::REG_COUNT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/parallel_port_atapi_bridge.sv
// Parallel port to ATAPI bridge: unlock recognizer, connect logic and register file.
// An accepted request passes through the input register, then the result register.
// Throughput: one request per cycle when the result side does not stall, set by the
// single pass of logic between the two registers and the one-write-port register file RAM.
// Reset (rst, synchronous) clears all control state; the register file reads as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
module parallel_port_atapi_bridge #(
  parameter int REG_COUNT = ppab_pkg::REG_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       link_connected
);

  localparam int AW = $clog2(REG_COUNT);
  localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);

  localparam logic [7:0] CMD_CONNECT    = 8'hE0;
  localparam logic [7:0] CMD_DISCONNECT = 8'h30;
  localparam logic [7:0] STAT_IDLE      = 8'h38;
  localparam logic [7:0] STAT_CHECK5    = 8'hB8;
  localparam logic [7:0] STAT_CHECK6    = 8'h58;
  localparam logic [7:0] STAT_UNLOCKED  = 8'hF0;
  localparam logic [7:0] TAG_MASK       = 8'h60;
  localparam logic [7:0] ADDR_MASK      = 8'h9F;
  localparam logic [7:0] REG_DEVCTL     = 8'h16;
  localparam logic [7:0] CTRL_RESYNC    = 8'h01;
  localparam logic [7:0] CTRL_LOW_NIB   = 8'h03;
  localparam logic [7:0] CTRL_HIGH_NIB  = 8'h04;
  localparam logic [3:0] NIBBLE_FILL    = 4'h8;

  typedef enum logic [1:0] {
    MODE_DATA_WR,
    MODE_CTRL_WR,
    MODE_STATUS_RD,
    MODE_CTRL_RD
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_CMD
  } phase_t;

  // Input register.
  logic       s1_valid;
  mode_t      s1_mode;
  logic [7:0] s1_value;
  logic       go;

  // Bridge state.
  logic [7:0] ctrl, ctrl_next;
  logic [7:0] stat, stat_next;
  phase_t     phase, phase_next;
  logic [2:0] pos, pos_next;
  logic [7:0] prev, prev_next;
  logic       rep, rep_next;
  logic [7:0] cmd, cmd_next;
  logic       conn, conn_next;
  logic [7:0] addr, addr_next;
  logic       wpend, wpend_next;
  logic       hi_sel, hi_sel_next;

  // Register file bookkeeping.
  logic [REG_COUNT-1:0] reg_valid, reg_valid_next;
  logic                 tf_def, tf_def_next;
  logic                 byp_hit, byp_hit_next;
  logic [7:0]           byp_data;
  logic                 we, dev_rst;
  logic [7:0]           ram_rdata;
  logic                 in_range;
  logic [7:0]           file_val;
  logic [7:0]           rd;

  assign go       = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !go;
  assign in_range = {1'b0, addr} < REG_LIMIT;

  ppab_ram #(
    .WIDTH(ppab_pkg::BYTE_W),
    .DEPTH(REG_COUNT)
  ) u_regfile (
    .clk  (clk),
    .we   (we),
    .waddr(addr[AW-1:0]),
    .wdata(s1_value),
    .raddr(addr_next[AW-1:0]),
    .rdata(ram_rdata)
  );

  // The RAM always holds a read of the addressed register; a write to it in the
  // previous cycles is served from the bypass register instead.
  always_comb begin
    if (!in_range) begin
      file_val = 8'h00;
    end else if (!reg_valid[addr[AW-1:0]]) begin
      file_val = tf_def ? ppab_pkg::taskfile_default(addr) : 8'h00;
    end else if (byp_hit) begin
      file_val = byp_data;
    end else begin
      file_val = ram_rdata;
    end
  end

  always_comb begin
    ctrl_next   = ctrl;
    stat_next   = stat;
    phase_next  = phase;
    pos_next    = pos;
    prev_next   = prev;
    rep_next    = rep;
    cmd_next    = cmd;
    conn_next   = conn;
    addr_next   = addr;
    wpend_next  = wpend;
    hi_sel_next = hi_sel;
    we          = 1'b0;
    dev_rst     = 1'b0;
    rd          = 8'h00;
    if (go) begin
      unique case (s1_mode)
        MODE_DATA_WR: begin
          if (rep && s1_value == prev) begin
            rep_next = 1'b0;
          end else begin
            prev_next = s1_value;
            rep_next  = 1'b1;
            if (phase == PH_CMD) begin
              cmd_next   = s1_value;
              phase_next = PH_IDLE;
            end else if (pos != 3'd7 && s1_value == ppab_pkg::preamble_byte(pos)) begin
              pos_next   = 3'(pos + 3'd1);
              phase_next = PH_RUN;
              if (pos == 3'd4) begin
                stat_next = STAT_CHECK5;
              end else if (pos == 3'd5) begin
                stat_next = STAT_CHECK6;
              end else if (pos == 3'd6) begin
                stat_next  = STAT_UNLOCKED;
                phase_next = PH_CMD;
              end
            end else if (s1_value == ppab_pkg::preamble_byte(3'd0)) begin
              pos_next   = 3'd1;
              phase_next = PH_RUN;
            end else begin
              pos_next   = 3'd0;
              phase_next = PH_IDLE;
            end
          end
          if (phase_next == PH_IDLE && cmd_next == 8'h00 && conn) begin
            if (wpend) begin
              wpend_next = 1'b0;
              if (in_range) begin
                we = 1'b1;
                if (addr == REG_DEVCTL && !s1_value[2]) begin
                  dev_rst = 1'b1;
                end
              end
            end else if ((s1_value & TAG_MASK) != 8'h00) begin
              addr_next  = s1_value & ADDR_MASK;
              wpend_next = 1'b1;
            end else begin
              addr_next   = s1_value;
              hi_sel_next = 1'b0;
            end
          end
        end
        MODE_CTRL_WR: begin
          if (!ctrl[0] && s1_value[0] && phase == PH_IDLE && cmd != 8'h00) begin
            if (cmd == CMD_CONNECT) begin
              conn_next = 1'b1;
              stat_next = STAT_IDLE;
            end else if (cmd == CMD_DISCONNECT) begin
              conn_next = 1'b0;
              stat_next = STAT_IDLE;
            end
            cmd_next = 8'h00;
            pos_next = 3'd0;
          end
          if (conn_next && s1_value == CTRL_RESYNC) begin
            phase_next  = PH_IDLE;
            pos_next    = 3'd0;
            hi_sel_next = 1'b0;
          end else if (conn_next && s1_value == CTRL_LOW_NIB) begin
            hi_sel_next = 1'b0;
          end else if (conn_next && s1_value == CTRL_HIGH_NIB && cmd_next == 8'h00) begin
            hi_sel_next = 1'b1;
          end
          ctrl_next = s1_value;
        end
        MODE_STATUS_RD: begin
          if (phase != PH_IDLE || !conn || !in_range) begin
            rd = stat;
          end else if (hi_sel) begin
            rd = {file_val[7:4], NIBBLE_FILL};
          end else begin
            rd = {file_val[3:0], NIBBLE_FILL};
          end
        end
        MODE_CTRL_RD: begin
          rd = ctrl;
        end
        default: begin
          rd = 8'h00;
        end
      endcase
    end
  end

  always_comb begin
    reg_valid_next = reg_valid;
    tf_def_next    = tf_def;
    byp_hit_next   = byp_hit;
    if (dev_rst) begin
      reg_valid_next = '0;
      tf_def_next    = 1'b1;
    end else if (we) begin
      reg_valid_next[addr[AW-1:0]] = 1'b1;
    end
    if (we) begin
      byp_hit_next = 1'b1;
    end else if (addr_next != addr) begin
      byp_hit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      ctrl      <= 8'h00;
      stat      <= STAT_IDLE;
      phase     <= PH_IDLE;
      pos       <= 3'd0;
      prev      <= 8'h00;
      rep       <= 1'b0;
      cmd       <= 8'h00;
      conn      <= 1'b0;
      addr      <= 8'h00;
      wpend     <= 1'b0;
      hi_sel    <= 1'b0;
      reg_valid <= '0;
      tf_def    <= 1'b0;
      byp_hit   <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      ctrl      <= ctrl_next;
      stat      <= stat_next;
      phase     <= phase_next;
      pos       <= pos_next;
      prev      <= prev_next;
      rep       <= rep_next;
      cmd       <= cmd_next;
      conn      <= conn_next;
      addr      <= addr_next;
      wpend     <= wpend_next;
      hi_sel    <= hi_sel_next;
      reg_valid <= reg_valid_next;
      tf_def    <= tf_def_next;
      byp_hit   <= byp_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_mode  <= mode_t'(mode);
      s1_value <= value;
    end
    if (we) begin
      byp_data <= s1_value;
    end
    if (go) begin
      read_data      <= rd;
      link_connected <= conn_next;
    end
  end

  // The link state moves only when a request is processed.
  assert property (@(posedge clk) disable iff (rst) !go |=> $stable(conn))
    else $error("link state changed without a request");

  // The command byte is expected only once the full preamble has matched.
  assert property (@(posedge clk) disable iff (rst) phase == PH_CMD |-> pos == 3'd7)
    else $error("command phase entered before the preamble completed");

  // A device reset leaves every entry at its task file default.
  assert property (@(posedge clk) disable iff (rst) dev_rst |=> reg_valid == '0 && tf_def)
    else $error("device reset did not clear the register file");

  // The input side is held off only while an unfinished request sits in the input register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> s1_valid && out_valid)
    else $error("input stalled with no request waiting");

endmodule

### tb/sv/tb_parallel_port_atapi_bridge.sv
`timescale 1ns / 100ps
// Self-checking testbench for parallel_port_atapi_bridge: unlock, connect, register file.
// Depends on ppab_pkg and the bridge RTL; predicts every port access in-line.
module tb_parallel_port_atapi_bridge;

  localparam int NREGS       = ppab_pkg::REG_COUNT;
  localparam int NREG_AW     = $clog2(NREGS);
  localparam logic [8:0] REG_LIMIT = 9'(NREGS);
  localparam int ITEMS       = 1000;
  localparam int CALM_ITEMS  = 120;
  localparam int RATE_PERIOD = 300;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [7:0] UNLOCK_SEQ [0:6] = '{8'h22, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h87, 8'h78};
  localparam logic [7:0] CMD_CONNECT    = 8'hE0;
  localparam logic [7:0] CMD_DISCONNECT = 8'h30;
  localparam logic [7:0] ST_IDLE        = 8'h38;
  localparam logic [7:0] ST_CHECK5      = 8'hB8;
  localparam logic [7:0] ST_CHECK6      = 8'h58;
  localparam logic [7:0] ST_CHECK7      = 8'hF0;
  localparam logic [7:0] WR_TAG_MASK    = 8'h60;
  localparam logic [7:0] ADDR_MASK      = 8'h9F;
  localparam logic [7:0] REG_DEVCTL     = 8'h16;
  localparam logic [7:0] DEVCTL_SRST_N  = 8'h04;
  localparam logic [7:0] REG_STATUS     = 8'h1F;
  localparam logic [7:0] REG_LBA_MID    = 8'h1C;
  localparam logic [7:0] REG_LBA_HIGH   = 8'h1D;
  localparam logic [7:0] STATUS_RESET   = 8'h50;
  localparam logic [7:0] SIG_LBA_MID    = 8'h14;
  localparam logic [7:0] SIG_LBA_HIGH   = 8'hEB;
  localparam logic [7:0] NIBBLE_MARK    = 8'h08;
  localparam logic [7:0] CTL_RESYNC     = 8'h01;
  localparam logic [7:0] CTL_NIB_LOW    = 8'h03;
  localparam logic [7:0] CTL_NIB_HIGH   = 8'h04;

  typedef enum logic [1:0] {
    OP_DATA_WR   = 2'd0,
    OP_CTRL_WR   = 2'd1,
    OP_STATUS_RD = 2'd2,
    OP_CTRL_RD   = 2'd3
  } port_op_t;

  typedef enum logic [1:0] {
    UNLOCK_IDLE  = 2'd0,
    UNLOCK_MATCH = 2'd1,
    UNLOCK_CMD   = 2'd2
  } unlock_t;

  typedef struct packed {
    port_op_t   op;
    logic [7:0] data;
    logic       hold;
  } port_req_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       link;
  } port_resp_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = 2'd0;
  logic [7:0] value = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       link_connected;

  parallel_port_atapi_bridge u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .link_connected (link_connected)
  );

  port_req_t  pending_q [$];
  port_resp_t result_q [$];
  port_req_t  next_req;
  port_resp_t got_resp;
  port_resp_t want_resp;
  int         stim_count = 0;
  int         mismatches = 0;
  int         cycle_cnt = 0;
  int         gap_left = 0;
  int         gap_pct = 0;
  int         stall_left = 0;
  int         stall_pct = 0;
  logic       holding = 1'b0;
  logic       calm = 1'b0;

  // Bridge state as seen by the host.
  logic [7:0] br_ctrl;
  logic [7:0] br_status;
  unlock_t    br_phase;
  logic [2:0] br_pos;
  logic [7:0] br_last;
  logic       br_dup;
  logic [7:0] br_cmd;
  logic       br_link;
  logic [7:0] br_addr;
  logic       br_wr_armed;
  logic       br_hi_nib;
  logic [7:0] br_regs [NREGS];

  function automatic void bridge_reset();
    br_ctrl     = 8'h00;
    br_status   = ST_IDLE;
    br_phase    = UNLOCK_IDLE;
    br_pos      = 3'd0;
    br_last     = 8'h00;
    br_dup      = 1'b0;
    br_cmd      = 8'h00;
    br_link     = 1'b0;
    br_addr     = 8'h00;
    br_wr_armed = 1'b0;
    br_hi_nib   = 1'b0;
    for (int i = 0; i < NREGS; i++) br_regs[i] = 8'h00;
  endfunction

  function automatic void taskfile_reset();
    for (int i = 0; i < NREGS; i++) br_regs[i] = 8'h00;
    br_regs[REG_STATUS[NREG_AW-1:0]]   = STATUS_RESET;
    br_regs[REG_LBA_MID[NREG_AW-1:0]]  = SIG_LBA_MID;
    br_regs[REG_LBA_HIGH[NREG_AW-1:0]] = SIG_LBA_HIGH;
  endfunction

  function automatic void unlock_step(input logic [7:0] v);
    // When the host sends a byte twice in a row, the second copy only clears the flag.
    if (br_dup && v == br_last) begin
      br_dup = 1'b0;
      return;
    end
    br_last = v;
    br_dup  = 1'b1;
    if (br_phase == UNLOCK_CMD) begin
      br_cmd   = v;
      br_phase = UNLOCK_IDLE;
      return;
    end
    if (br_pos < 3'd7 && v == UNLOCK_SEQ[br_pos]) begin
      br_pos   = br_pos + 3'd1;
      br_phase = UNLOCK_MATCH;
      case (br_pos)
        3'd5: br_status = ST_CHECK5;
        3'd6: br_status = ST_CHECK6;
        3'd7: begin
          br_status = ST_CHECK7;
          br_phase  = UNLOCK_CMD;
        end
        default: ;
      endcase
      return;
    end
    br_pos   = (v == UNLOCK_SEQ[0]) ? 3'd1 : 3'd0;
    br_phase = (br_pos != 3'd0) ? UNLOCK_MATCH : UNLOCK_IDLE;
  endfunction

  function automatic void data_write(input logic [7:0] v);
    unlock_step(v);
    if (br_phase != UNLOCK_IDLE || br_cmd != 8'h00 || !br_link) return;
    if (br_wr_armed) begin
      br_wr_armed = 1'b0;
      if ({1'b0, br_addr} < REG_LIMIT) begin
        br_regs[br_addr[NREG_AW-1:0]] = v;
        if (br_addr == REG_DEVCTL && (v & DEVCTL_SRST_N) == 8'h00) taskfile_reset();
      end
    end else if ((v & WR_TAG_MASK) != 8'h00) begin
      br_addr     = v & ADDR_MASK;
      br_wr_armed = 1'b1;
    end else begin
      br_addr   = v;
      br_hi_nib = 1'b0;
    end
  endfunction

  function automatic void ctrl_write(input logic [7:0] v);
    if (!br_ctrl[0] && v[0] && br_phase == UNLOCK_IDLE && br_cmd != 8'h00) begin
      if (br_cmd == CMD_CONNECT) begin
        br_link   = 1'b1;
        br_status = ST_IDLE;
      end else if (br_cmd == CMD_DISCONNECT) begin
        br_link   = 1'b0;
        br_status = ST_IDLE;
      end
      br_cmd = 8'h00;
      br_pos = 3'd0;
    end
    if (br_link && v == CTL_RESYNC) begin
      br_phase  = UNLOCK_IDLE;
      br_pos    = 3'd0;
      br_hi_nib = 1'b0;
    end else if (br_link && v == CTL_NIB_LOW) begin
      br_hi_nib = 1'b0;
    end else if (br_link && v == CTL_NIB_HIGH && br_cmd == 8'h00) begin
      br_hi_nib = 1'b1;
    end
    br_ctrl = v;
  endfunction

  function automatic logic [7:0] status_byte();
    logic [7:0] r;
    if (br_phase != UNLOCK_IDLE || !br_link || {1'b0, br_addr} >= REG_LIMIT) return br_status;
    r = br_regs[br_addr[NREG_AW-1:0]];
    if (br_hi_nib) return (r & 8'hF0) | NIBBLE_MARK;
    return {r[3:0], 4'h0} | NIBBLE_MARK;
  endfunction

  function automatic port_resp_t bridge_access(input port_op_t op, input logic [7:0] v);
    port_resp_t r;
    r.rd = 8'h00;
    case (op)
      OP_DATA_WR:   data_write(v);
      OP_CTRL_WR:   ctrl_write(v);
      OP_STATUS_RD: r.rd = status_byte();
      default:      r.rd = br_ctrl;
    endcase
    r.link = br_link;
    return r;
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  task automatic push_req(input port_op_t op, input logic [7:0] v);
    pending_q.push_back('{op, v, 1'b0});
    stim_count++;
  endtask

  task automatic push_hold();
    pending_q.push_back('{OP_CTRL_RD, 8'h00, 1'b1});
  endtask

  // Preamble plus command byte, bytes sometimes doubled, checkpoints sometimes read.
  task automatic push_unlock(input logic [7:0] cmd);
    for (int i = 0; i < 7; i++) begin
      push_req(OP_DATA_WR, UNLOCK_SEQ[i]);
      if ($urandom_range(0, 1) == 0) push_req(OP_DATA_WR, UNLOCK_SEQ[i]);
      if ($urandom_range(0, 3) == 0) push_req(OP_STATUS_RD, 8'($urandom));
    end
    push_req(OP_DATA_WR, cmd);
    if ($urandom_range(0, 1) == 0) push_req(OP_DATA_WR, cmd);
  endtask

  // A low then high write of control bit 0 commits the command.
  task automatic push_commit();
    if ($urandom_range(0, 3) == 0) push_req(OP_CTRL_WR, 8'($urandom) & 8'hFE);
    else push_req(OP_CTRL_WR, 8'h00);
    if ($urandom_range(0, 3) == 0) push_req(OP_CTRL_WR, 8'($urandom) | 8'h01);
    else push_req(OP_CTRL_WR, CTL_RESYNC);
  endtask

  task automatic push_reg_ops(input int n);
    logic [7:0] a;
    for (int i = 0; i < n; i++) begin
      a = 8'($urandom_range(0, NREGS - 1));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          push_req(OP_DATA_WR, {($urandom_range(0, 7) == 0), 2'($urandom_range(1, 3)), a[4:0]});
          push_req(OP_DATA_WR, 8'($urandom));
        end
        3: begin
          push_req(OP_DATA_WR, {1'b0, 2'($urandom_range(1, 3)), REG_DEVCTL[4:0]});
          push_req(OP_DATA_WR, 8'($urandom));
        end
        4, 5: begin
          push_req(OP_DATA_WR, {($urandom_range(0, 7) == 0), 2'b00, a[4:0]});
          push_req(OP_STATUS_RD, 8'($urandom));
          if ($urandom_range(0, 1) == 0) push_req(OP_STATUS_RD, 8'($urandom));
        end
        6: begin
          push_req(OP_CTRL_WR, CTL_NIB_HIGH);
          push_req(OP_STATUS_RD, 8'($urandom));
        end
        7: push_req(OP_CTRL_WR, ($urandom_range(0, 1) == 0) ? CTL_NIB_LOW : CTL_RESYNC);
        8: push_req(OP_CTRL_RD, 8'($urandom));
        default: push_req(port_op_t'($urandom_range(0, 3)), 8'($urandom));
      endcase
    end
  endtask

  task automatic push_directed();
    push_req(OP_STATUS_RD, 8'h00);
    push_req(OP_CTRL_RD, 8'hFF);
    push_req(OP_CTRL_WR, 8'hFF);
    push_req(OP_CTRL_RD, 8'h00);
    push_req(OP_CTRL_WR, 8'h00);
    push_req(OP_DATA_WR, 8'hFF);
    push_req(OP_DATA_WR, 8'hFF);
    for (int i = 0; i < 7; i++) push_req(OP_DATA_WR, UNLOCK_SEQ[i]);
    push_req(OP_STATUS_RD, 8'h00);
    push_req(OP_DATA_WR, CMD_CONNECT);
    // Past the end of the preamble: a stray byte is a plain mismatch.
    push_req(OP_DATA_WR, 8'h5A);
    push_req(OP_CTRL_WR, CTL_RESYNC);
    push_req(OP_DATA_WR, 8'h3F);
    push_req(OP_DATA_WR, 8'hA5);
    push_req(OP_CTRL_WR, CTL_NIB_HIGH);
    push_req(OP_STATUS_RD, 8'h00);
    // Out-of-range register: nothing stored, status reads fall back.
    push_req(OP_DATA_WR, 8'hFF);
    push_req(OP_DATA_WR, 8'h11);
    push_req(OP_STATUS_RD, 8'h00);
    // Device reset through device control with bit 2 clear.
    push_req(OP_DATA_WR, 8'h36);
    push_req(OP_DATA_WR, 8'h00);
    push_req(OP_DATA_WR, REG_LBA_HIGH);
    push_req(OP_STATUS_RD, 8'h00);
  endtask

  task automatic push_random();
    int n;
    while (stim_count < ITEMS) begin
      if (stim_count > ITEMS / 2 && stim_count < ITEMS / 2 + 40) push_hold();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          push_unlock(CMD_CONNECT);
          push_commit();
          push_reg_ops($urandom_range(4, 24));
          case ($urandom_range(0, 4))
            0, 1: begin
              push_unlock(CMD_DISCONNECT);
              push_commit();
            end
            2: begin
              push_unlock(8'($urandom));
              push_commit();
            end
            3: begin
              push_unlock(8'h00);
              push_req(OP_DATA_WR, 8'($urandom));
              push_commit();
            end
            default: ;
          endcase
        end
        7: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) push_req(OP_DATA_WR, UNLOCK_SEQ[i]);
          push_req(OP_DATA_WR, 8'($urandom));
          push_req(OP_STATUS_RD, 8'($urandom));
          push_commit();
        end
        default: begin
          for (int i = 0; i < 10; i++) push_req(port_op_t'($urandom_range(0, 3)), 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests queued and %0d results outstanding",
               $time, pending_q.size(), result_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      holding  <= 1'b0;
    end else begin
      calm <= (pending_q.size() < CALM_ITEMS);
      if (cycle_cnt % RATE_PERIOD == 0) gap_pct <= pick_rate();
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (holding) begin
          in_valid <= 1'b0;
          if (result_q.size() == 0) holding <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_q[0].hold) begin
          void'(pending_q.pop_front());
          in_valid <= 1'b0;
          holding  <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 17);
        end else begin
          next_req = pending_q.pop_front();
          in_valid <= 1'b1;
          mode     <= next_req.op;
          value    <= next_req.data;
        end
      end
    end
  end

  // Result-side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (cycle_cnt % RATE_PERIOD == RATE_PERIOD / 2) stall_pct <= pick_rate();
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 17);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest prediction, then predict new requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual read_data=%h link=%b",
                   $time, read_data, link_connected);
          mismatches++;
        end else begin
          got_resp = result_q.pop_front();
          if (read_data !== got_resp.rd) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, got_resp.rd, read_data);
            mismatches++;
          end
          if (link_connected !== got_resp.link) begin
            $display("%0t: link_connected mismatch: expected %b, actual %b",
                     $time, got_resp.link, link_connected);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want_resp = bridge_access(port_op_t'(mode), value);
        result_q.push_back(want_resp);
      end
    end
  end

  initial begin
    bridge_reset();
    push_directed();
    push_hold();
    push_random();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || holding || result_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d results missing, oldest expected read_data=%h link=%b, actual none",
               $time, result_q.size(), result_q[0].rd, result_q[0].link);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
